### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Assertion helpers shared by the ray-box intersection RTL.
// ---------------------------------------------------------------------------
// Every macro samples on the rising edge of clock and is disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// When the trigger holds, the consequence must hold in the same cycle.
`define ASSERT_IMPLIES(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cons)) \
      else $error(msg);

`endif

### sv/rbi_pkg.sv
// ---------------------------------------------------------------------------
// Ray-box intersection package
// Shared widths, types and codes for the intersection pipeline.
// ---------------------------------------------------------------------------
package rbi_pkg;

   // Coordinate format: signed fixed point.
   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int NUM_AXES    = 3;

   // Divider: quotient bits resolved per pipeline stage.
   localparam int DIV_STEPS  = 4;
   localparam int DIV_STAGES = (COORD_WIDTH + DIV_STEPS - 1) / DIV_STEPS;
   // Registers from the divider input to the registered distance.
   localparam int DIV_LAT    = DIV_STAGES + 3;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef coord_type [NUM_AXES-1:0]      vec_type;

   // Distance used for an axis that offers no entry plane: minus one.
   localparam coord_type NEG_ONE_FX = ~(coord_type'(1) << FRAC_BITS) + coord_type'(1);

   // Entry axis codes.
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // Per-request geometry carried alongside the distance pipeline.
   typedef struct packed {
      logic    org_in;
      vec_type org;
      vec_type dir;
      vec_type low;
      vec_type high;
      vec_type plane;
   } side_type;

endpackage

### sv/rbi_divider.sv
// ---------------------------------------------------------------------------
// Ray-box distance divider
// Pipelined restoring divider: t = trunc(num * 2^FRAC_BITS / den), saturated.
// ---------------------------------------------------------------------------
module rbi_divider (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 valid_i,
   input  logic                                 active_i,
   input  logic signed [rbi_pkg::COORD_WIDTH:0] num_i,
   input  rbi_pkg::coord_type                   den_i,
   output logic                                 valid_o,
   output rbi_pkg::coord_type                   dist_o
);

   localparam int W  = rbi_pkg::COORD_WIDTH;
   localparam int F  = rbi_pkg::FRAC_BITS;
   localparam int CW = 2 * W + F + 1;
   localparam int DS = rbi_pkg::DIV_STAGES;
   localparam int DN = rbi_pkg::DIV_STEPS;
   localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};

   typedef struct packed {
      logic         valid;
      logic         active;
      logic         neg;
      logic         ovf;
      logic [W-1:0] den;
      logic [W-1:0] rem;
      logic [W-1:0] low;
      logic [W-1:0] quo;
   } div_stage_type;

   // Resolves the quotient bits of one stage, most significant first.
   function automatic div_stage_type div_step(div_stage_type s, int k);
      div_stage_type r;
      logic [W:0]    trial;
      r = s;
      for (int j = 0; j < DN; j++) begin
         if (k * DN + j < W) begin
            trial = {r.rem, r.low[W-1]};
            r.low = {r.low[W-2:0], 1'b0};
            if (trial >= {1'b0, r.den}) begin
               r.rem = W'(trial - {1'b0, r.den});
               r.quo = {r.quo[W-2:0], 1'b1};
            end else begin
               r.rem = trial[W-1:0];
               r.quo = {r.quo[W-2:0], 1'b0};
            end
         end
      end
      return r;
   endfunction

   logic              s0_valid_ff, s0_active_ff, s0_neg_ff;
   logic [W:0]        s0_nmag_ff;
   logic [W-1:0]      s0_dmag_ff;
   div_stage_type     st_ff [DS+1];
   div_stage_type     st_in [DS+1];
   logic              out_valid_ff;
   rbi_pkg::coord_type dist_ff, dist_in;
   logic [CW-1:0]     num_wide, den_wide;

   // Magnitudes and sign of the quotient.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= valid_i;
      end
      s0_active_ff <= active_i;
      s0_neg_ff    <= num_i[W] ^ den_i[W-1];
      s0_nmag_ff   <= num_i[W] ? (W+1)'(-num_i) : num_i;
      s0_dmag_ff   <= den_i[W-1] ? W'(-den_i) : den_i;
   end

   // Overflow check and initial partial remainder; reset clears the stage valid bits.
   always_comb begin
      num_wide = CW'({s0_nmag_ff, {F{1'b0}}});
      den_wide = CW'({s0_dmag_ff, {W{1'b0}}});
      st_in[0].valid  = s0_valid_ff && !reset;
      st_in[0].active = s0_active_ff;
      st_in[0].neg    = s0_neg_ff;
      st_in[0].ovf    = num_wide >= den_wide;
      st_in[0].den    = s0_dmag_ff;
      st_in[0].rem    = W'(s0_nmag_ff >> (W - F));
      st_in[0].low    = W'({s0_nmag_ff, {F{1'b0}}});
      st_in[0].quo    = '0;
      for (int k = 0; k < DS; k++) begin
         st_in[k+1]       = div_step(st_ff[k], k);
         st_in[k+1].valid = st_ff[k].valid && !reset;
      end
   end

   // Stage registers of the divider.
   always_ff @(posedge clock) begin
      for (int k = 0; k <= DS; k++) begin
         st_ff[k] <= st_in[k];
      end
   end

   // Saturation and the no-plane distance.
   always_comb begin
      if (!st_ff[DS].active) begin
         dist_in = rbi_pkg::NEG_ONE_FX;
      end else if (st_ff[DS].neg) begin
         dist_in = (st_ff[DS].ovf || st_ff[DS].quo > HALF) ? HALF : ~st_ff[DS].quo + 1'b1;
      end else begin
         dist_in = (st_ff[DS].ovf || st_ff[DS].quo > ~HALF) ? ~HALF : st_ff[DS].quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= st_ff[DS].valid;
      end
      dist_ff <= dist_in;
   end

   assign valid_o = out_valid_ff;
   assign dist_o  = dist_ff;

endmodule

### sv/ray_box_intersection_core.sv
// ---------------------------------------------------------------------------
// Ray-box intersection core
// Slab-test ray against axis-aligned box, one request per clock.
// ---------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  request   start, busy          req_origin_*, req_direction_*, req_box_*
//  result    rsp_valid (strobe)   rsp_hit, rsp_origin_inside, rsp_hit_axis,
//                                 rsp_point_*
//
// A request is taken in every cycle; busy stays low. Each result passes the
// input registers, the dividers and the select, product, point and output
// registers, in that order. Each divider resolves four quotient bits per
// stage.
// Synchronous reset clears every valid bit; payload registers keep no reset.
// The receiver cannot stall, so nothing in the pipeline ever holds.
`include "assert_macros.svh"

module ray_box_intersection_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  rbi_pkg::coord_type req_origin_x,
   input  rbi_pkg::coord_type req_origin_y,
   input  rbi_pkg::coord_type req_origin_z,
   input  rbi_pkg::coord_type req_direction_x,
   input  rbi_pkg::coord_type req_direction_y,
   input  rbi_pkg::coord_type req_direction_z,
   input  rbi_pkg::coord_type req_box_low_x,
   input  rbi_pkg::coord_type req_box_low_y,
   input  rbi_pkg::coord_type req_box_low_z,
   input  rbi_pkg::coord_type req_box_high_x,
   input  rbi_pkg::coord_type req_box_high_y,
   input  rbi_pkg::coord_type req_box_high_z,
   output logic               rsp_valid,
   output logic               rsp_hit,
   output logic               rsp_origin_inside,
   output logic [1:0]         rsp_hit_axis,
   output rbi_pkg::coord_type rsp_point_x,
   output rbi_pkg::coord_type rsp_point_y,
   output rbi_pkg::coord_type rsp_point_z
);

   localparam int W  = rbi_pkg::COORD_WIDTH;
   localparam int F  = rbi_pkg::FRAC_BITS;
   localparam int NA = rbi_pkg::NUM_AXES;
   localparam int L  = rbi_pkg::DIV_LAT;
   localparam int SL = L + 3;
   localparam logic [W:0] WALK_LIM = {1'b1, {W{1'b0}}};

   // Input registers.
   logic              v0_ff;
   rbi_pkg::vec_type  org_ff, dir_ff, low_ff, high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start;
      end
      org_ff  <= {req_origin_z, req_origin_y, req_origin_x};
      dir_ff  <= {req_direction_z, req_direction_y, req_direction_x};
      low_ff  <= {req_box_low_z, req_box_low_y, req_box_low_x};
      high_ff <= {req_box_high_z, req_box_high_y, req_box_high_x};
   end

   assign busy = 1'b0;

   // Classify each axis against its slab and form the plane offset.
   rbi_pkg::side_type      side_new;
   logic [NA-1:0]          active;
   logic signed [W:0]      num [NA];

   always_comb begin
      side_new.org    = org_ff;
      side_new.dir    = dir_ff;
      side_new.low    = low_ff;
      side_new.high   = high_ff;
      side_new.org_in = 1'b1;
      for (int i = 0; i < NA; i++) begin
         side_new.plane[i] = '0;
         active[i]         = 1'b0;
         if ($signed(org_ff[i]) < $signed(low_ff[i])) begin
            side_new.plane[i] = low_ff[i];
            side_new.org_in   = 1'b0;
            active[i]         = 1'b1;
         end else if ($signed(org_ff[i]) > $signed(high_ff[i])) begin
            side_new.plane[i] = high_ff[i];
            side_new.org_in   = 1'b0;
            active[i]         = 1'b1;
         end
         active[i] = active[i] && (dir_ff[i] != '0);
         num[i] = $signed({side_new.plane[i][W-1], side_new.plane[i]})
                - $signed({org_ff[i][W-1], org_ff[i]});
      end
   end

   // One divider per axis.
   logic [NA-1:0]      div_valid;
   rbi_pkg::coord_type dist_t [NA];

   for (genvar g = 0; g < NA; g++) begin : g_div
      rbi_divider u_div (
         .clock    (clock),
         .reset    (reset),
         .valid_i  (v0_ff),
         .active_i (active[g]),
         .num_i    (num[g]),
         .den_i    (dir_ff[g]),
         .valid_o  (div_valid[g]),
         .dist_o   (dist_t[g])
      );
   end

   // Geometry delay line that tracks the divider and the later stages.
   rbi_pkg::side_type side_ff [SL];
   logic [SL-1:0]     vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[SL-2:0], v0_ff};
      end
      side_ff[0] <= side_new;
      for (int k = 1; k < SL; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
   end

   // Pick the first largest distance.
   rbi_pkg::coord_type tw_ff, tw_in;
   logic [1:0]         w_ff, w_in;
   logic               miss_ff;

   always_comb begin
      tw_in = dist_t[0];
      w_in  = rbi_pkg::AXIS_X;
      if ($signed(tw_in) < $signed(dist_t[1])) begin
         tw_in = dist_t[1];
         w_in  = rbi_pkg::AXIS_Y;
      end
      if ($signed(tw_in) < $signed(dist_t[2])) begin
         tw_in = dist_t[2];
         w_in  = rbi_pkg::AXIS_Z;
      end
   end

   always_ff @(posedge clock) begin
      tw_ff   <= tw_in;
      w_ff    <= w_in;
      miss_ff <= tw_in[W-1];
   end

   // Multiply the winning distance by each direction component.
   logic [2*W-1:0] prod_ff [NA];
   logic [NA-1:0]  sgn_ff;
   logic [1:0]     w2_ff;
   logic           miss2_ff;
   logic [W-1:0]   tmag;

   assign tmag = tw_ff[W-1] ? W'(-tw_ff) : tw_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < NA; i++) begin
         prod_ff[i] <= tmag * (side_ff[L].dir[i][W-1] ? W'(-side_ff[L].dir[i])
                                                      : side_ff[L].dir[i]);
         sgn_ff[i]  <= tw_ff[W-1] ^ side_ff[L].dir[i][W-1];
      end
      w2_ff    <= w_ff;
      miss2_ff <= miss_ff;
   end

   // Scale, clamp and step from the origin.
   logic signed [W+1:0] pt_ff [NA];
   logic [W:0]          step [NA];
   logic [2*W-F-1:0]    scaled [NA];
   logic [1:0]          w3_ff;
   logic                miss3_ff;

   always_comb begin
      for (int i = 0; i < NA; i++) begin
         scaled[i] = prod_ff[i][2*W-1:F];
         step[i]   = (scaled[i] > (2*W-F)'(WALK_LIM)) ? WALK_LIM : (W+1)'(scaled[i]);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NA; i++) begin
         if (sgn_ff[i]) begin
            pt_ff[i] <= (W+2)'($signed(side_ff[L+1].org[i])) - $signed({1'b0, step[i]});
         end else begin
            pt_ff[i] <= (W+2)'($signed(side_ff[L+1].org[i])) + $signed({1'b0, step[i]});
         end
      end
      w3_ff    <= w2_ff;
      miss3_ff <= miss2_ff;
   end

   // Box check and result formatting.
   rbi_pkg::side_type side_last;
   logic              in_box;
   rbi_pkg::vec_type  point;
   logic              hit_in, inside_in;
   logic [1:0]        axis_in;
   rbi_pkg::vec_type  point_in;

   assign side_last = side_ff[L+2];

   always_comb begin
      in_box = 1'b1;
      for (int i = 0; i < NA; i++) begin
         point[i] = pt_ff[i][W-1:0];
         if (2'(i) == w3_ff) begin
            point[i] = side_last.plane[i];
         end else if (pt_ff[i] < (W+2)'($signed(side_last.low[i]))
                   || pt_ff[i] > (W+2)'($signed(side_last.high[i]))) begin
            in_box = 1'b0;
         end
      end
      hit_in    = 1'b0;
      inside_in = 1'b0;
      axis_in   = rbi_pkg::AXIS_X;
      point_in  = '0;
      if (side_last.org_in) begin
         hit_in    = 1'b1;
         inside_in = 1'b1;
         point_in  = side_last.org;
      end else if (!miss3_ff && in_box) begin
         hit_in   = 1'b1;
         axis_in  = w3_ff;
         point_in = point;
      end
   end

   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vld_ff[SL-1];
      end
      rsp_hit           <= hit_in;
      rsp_origin_inside <= inside_in;
      rsp_hit_axis      <= axis_in;
      rsp_point_x       <= point_in[0];
      rsp_point_y       <= point_in[1];
      rsp_point_z       <= point_in[2];
   end

   assign rsp_valid = rsp_valid_ff;

   // The dividers must stay in step with the geometry delay line.
   `ASSERT_ALWAYS(div_align_a, (div_valid == {NA{vld_ff[L-1]}}), "divider out of step")
   // An origin inside the box is always a hit on the x code.
   `ASSERT_IMPLIES(inside_hit_a, rsp_valid && rsp_origin_inside, rsp_hit && rsp_hit_axis == rbi_pkg::AXIS_X, "inside without hit")
   // A miss reports a zero point and axis.
   `ASSERT_IMPLIES(miss_zero_a, rsp_valid && !rsp_hit, rsp_point_x == '0 && rsp_point_y == '0 && rsp_point_z == '0 && rsp_hit_axis == '0, "miss with nonzero fields")

endmodule

### bench/ray_box_intersection_core_test.sv
// ---------------------------------------------------------------------------
// Ray-box intersection core testbench
// Drives directed and random ray/box requests in bursts and checks every
// result, field by field, against a bit-accurate fixed-point predictor or a typed-in result.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module ray_box_intersection_core_test;

   localparam int NUM_RANDOM = 500;
   localparam int DRAIN_CYCLES = rbi_pkg::DIV_LAT + 10;

   // One request: origin, direction, box corners.
   typedef struct {
      rbi_pkg::coord_type org  [3];
      rbi_pkg::coord_type dir  [3];
      rbi_pkg::coord_type low  [3];
      rbi_pkg::coord_type high [3];
   } ray_req_type;

   // One result.
   typedef struct {
      logic               hit;
      logic               org_in;
      logic [1:0]         axis;
      rbi_pkg::coord_type pt [3];
   } hit_rsp_type;

   // Directed row: request plus an optional typed-in result.
   typedef struct {
      ray_req_type req;
      bit          has_exp;
      hit_rsp_type exp;
   } direct_row_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   logic      busy;
   rbi_pkg::coord_type req_origin_x = '0, req_origin_y = '0, req_origin_z = '0;
   rbi_pkg::coord_type req_direction_x = '0, req_direction_y = '0, req_direction_z = '0;
   rbi_pkg::coord_type req_box_low_x = '0, req_box_low_y = '0, req_box_low_z = '0;
   rbi_pkg::coord_type req_box_high_x = '0, req_box_high_y = '0, req_box_high_z = '0;
   logic               rsp_valid, rsp_hit, rsp_origin_inside;
   logic [1:0]         rsp_hit_axis;
   rbi_pkg::coord_type rsp_point_x, rsp_point_y, rsp_point_z;

   hit_rsp_type pending_hits [$];
   int          mismatch_count = 0;
   bit          finished = 1'b0;

   always #4 clock = ~clock;

   ray_box_intersection_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_origin_x(req_origin_x), .req_origin_y(req_origin_y),
      .req_origin_z(req_origin_z), .req_direction_x(req_direction_x),
      .req_direction_y(req_direction_y), .req_direction_z(req_direction_z),
      .req_box_low_x(req_box_low_x), .req_box_low_y(req_box_low_y),
      .req_box_low_z(req_box_low_z), .req_box_high_x(req_box_high_x),
      .req_box_high_y(req_box_high_y), .req_box_high_z(req_box_high_z),
      .rsp_valid(rsp_valid), .rsp_hit(rsp_hit), .rsp_origin_inside(rsp_origin_inside),
      .rsp_hit_axis(rsp_hit_axis), .rsp_point_x(rsp_point_x),
      .rsp_point_y(rsp_point_y), .rsp_point_z(rsp_point_z)
   );

   // Plane distance: trunc(num * 2^FRAC / den), saturated to the coordinate range.
   function automatic logic signed [63:0] plane_distance(logic signed [63:0] num,
                                                         logic signed [63:0] den);
      logic [127:0] n_mag;
      logic [127:0] d_mag;
      logic [127:0] quo;
      logic         neg;
      logic [127:0] lim;
      n_mag = (num < 0) ? 128'(-num) : 128'(num);
      d_mag = (den < 0) ? 128'(-den) : 128'(den);
      neg   = (num < 0) != (den < 0);
      quo   = (n_mag << rbi_pkg::FRAC_BITS) / d_mag;
      lim   = 128'(1) << (rbi_pkg::COORD_WIDTH - 1);
      if (neg)
         return (quo > lim) ? -64'(lim) : -64'(quo);
      return (quo > lim - 1) ? 64'(lim - 1) : 64'(quo);
   endfunction

   // Walk one coordinate along the ray by distance t, product clamped.
   function automatic logic signed [63:0] walk_coord(logic signed [63:0] src,
                                                     logic signed [63:0] t,
                                                     logic signed [63:0] d);
      logic [127:0] prod;
      logic [127:0] lim;
      prod = (128'((t < 0) ? -t : t) * 128'((d < 0) ? -d : d)) >> rbi_pkg::FRAC_BITS;
      lim  = 128'(1) << rbi_pkg::COORD_WIDTH;
      if (prod > lim) prod = lim;
      return ((t < 0) != (d < 0)) ? src - 64'(prod) : src + 64'(prod);
   endfunction

   // Predict the result of one request with Woo's slab classification.
   function automatic hit_rsp_type predict_hit(ray_req_type r);
      hit_rsp_type            res;
      logic signed [63:0]     plane [3];
      logic signed [63:0]     t_val [3];
      logic signed [63:0]     pt    [3];
      bit                     cand  [3];
      bit                     all_in;
      int                     w;
      res.hit = 1'b0; res.org_in = 1'b0; res.axis = rbi_pkg::AXIS_X;
      foreach (res.pt[i]) res.pt[i] = '0;
      all_in = 1'b1;
      for (int i = 0; i < 3; i++) begin
         cand[i] = 1'b1;
         plane[i] = 0;
         if (r.org[i] < r.low[i]) begin
            plane[i] = r.low[i]; all_in = 1'b0;
         end else if (r.org[i] > r.high[i]) begin
            plane[i] = r.high[i]; all_in = 1'b0;
         end else begin
            cand[i] = 1'b0;
         end
      end
      if (all_in) begin
         res.hit = 1'b1; res.org_in = 1'b1;
         foreach (res.pt[i]) res.pt[i] = r.org[i];
         return res;
      end
      for (int i = 0; i < 3; i++)
         t_val[i] = (cand[i] && r.dir[i] != 0) ?
                    plane_distance(plane[i] - 64'(r.org[i]), 64'(r.dir[i])) :
                    64'(rbi_pkg::NEG_ONE_FX);
      w = 0;
      for (int i = 1; i < 3; i++)
         if (t_val[w] < t_val[i]) w = i;
      if (t_val[w] < 0) return res;
      for (int i = 0; i < 3; i++) begin
         if (i == w) begin
            pt[i] = plane[i];
         end else begin
            pt[i] = walk_coord(64'(r.org[i]), t_val[w], 64'(r.dir[i]));
            if (pt[i] < 64'(r.low[i]) || pt[i] > 64'(r.high[i])) return res;
         end
      end
      res.hit = 1'b1;
      res.axis = 2'(w);
      foreach (res.pt[i]) res.pt[i] = rbi_pkg::coord_type'(pt[i]);
      return res;
   endfunction

   function automatic rbi_pkg::coord_type fx(int whole);
      return rbi_pkg::coord_type'(whole) <<< rbi_pkg::FRAC_BITS;
   endfunction

   function automatic ray_req_type make_req(
      rbi_pkg::coord_type ox, rbi_pkg::coord_type oy, rbi_pkg::coord_type oz,
      rbi_pkg::coord_type dx, rbi_pkg::coord_type dy, rbi_pkg::coord_type dz,
      rbi_pkg::coord_type lx, rbi_pkg::coord_type ly, rbi_pkg::coord_type lz,
      rbi_pkg::coord_type hx, rbi_pkg::coord_type hy, rbi_pkg::coord_type hz);
      ray_req_type r;
      r.org  = '{ox, oy, oz};
      r.dir  = '{dx, dy, dz};
      r.low  = '{lx, ly, lz};
      r.high = '{hx, hy, hz};
      return r;
   endfunction

   function automatic rbi_pkg::coord_type rand_coord();
      case ($urandom_range(0, 5))
         0: return rbi_pkg::coord_type'($urandom);
         1: return rbi_pkg::coord_type'({$urandom_range(0, 1) ? 32'h8000_0000
                                                              : 32'h7fff_ffff});
         2: return '0;
         default: return rbi_pkg::coord_type'(
                     $signed($urandom_range(0, 64 << rbi_pkg::FRAC_BITS))
                     - (32 << rbi_pkg::FRAC_BITS));
      endcase
   endfunction

   // Mostly well-formed boxes, rays aimed at the box centre in a third of cases; some pure noise.
   function automatic ray_req_type rand_req();
      ray_req_type        r;
      rbi_pkg::coord_type a, b;
      for (int i = 0; i < 3; i++) begin
         a = rand_coord(); b = rand_coord();
         if ($urandom_range(0, 9) != 0 && a > b) begin
            r.low[i] = b; r.high[i] = a;
         end else begin
            r.low[i] = a; r.high[i] = b;
         end
         r.org[i] = rand_coord();
         r.dir[i] = ($urandom_range(0, 7) == 0) ? rbi_pkg::coord_type'(0) : rand_coord();
      end
      if ($urandom_range(0, 2) == 0)
         for (int i = 0; i < 3; i++) r.dir[i] = rbi_pkg::coord_type'(32'(r.low[i]) / 2
                                    + 32'(r.high[i]) / 2 - 32'(r.org[i]));
      return r;
   endfunction

   // Present one request and hold it until accepted; leaves start high.
   task automatic send_request(ray_req_type r);
      start <= 1'b1;
      {req_origin_x, req_origin_y, req_origin_z} <= {r.org[0], r.org[1], r.org[2]};
      {req_direction_x, req_direction_y, req_direction_z} <= {r.dir[0], r.dir[1], r.dir[2]};
      {req_box_low_x, req_box_low_y, req_box_low_z} <= {r.low[0], r.low[1], r.low[2]};
      {req_box_high_x, req_box_high_y, req_box_high_z} <=
         {r.high[0], r.high[1], r.high[2]};
      do @(posedge clock); while (busy);
      pending_hits.push_back(predict_hit(r));
      @(negedge clock);
   endtask

   // Random gap between bursts.
   task automatic idle_gap(int cycles);
      start <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Compare each result strobe against the oldest expectation.
   always @(posedge clock) begin
      hit_rsp_type exp;
      if (!reset && rsp_valid) begin
         if (pending_hits.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("Unexpected result at %0t", $realtime);
         end else begin
            exp = pending_hits.pop_front();
            if (rsp_hit !== exp.hit || rsp_origin_inside !== exp.org_in ||
                rsp_hit_axis !== exp.axis || rsp_point_x !== exp.pt[0] ||
                rsp_point_y !== exp.pt[1] || rsp_point_z !== exp.pt[2]) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"Result mismatch at %0t: expected %b %b %0d %h %h %h,",
                            " got %b %b %0d %h %h %h"},
                           $realtime, exp.hit, exp.org_in, exp.axis, exp.pt[0], exp.pt[1],
                           exp.pt[2], rsp_hit, rsp_origin_inside, rsp_hit_axis,
                           rsp_point_x, rsp_point_y, rsp_point_z);
            end
         end
      end
   end

   // Stimulus: directed table, then random bursts.
   initial begin
      direct_row_type     rows [$];
      direct_row_type     row;
      hit_rsp_type        miss;
      rbi_pkg::coord_type mx, mn;
      int                 burst;
      mx = rbi_pkg::coord_type'(32'h7fff_ffff);
      mn = rbi_pkg::coord_type'(32'h8000_0000);
      miss.hit = 1'b0; miss.org_in = 1'b0; miss.axis = rbi_pkg::AXIS_X;
      miss.pt = '{0, 0, 0};

      // Origin inside the box: hit at the origin.
      row.req = make_req(fx(1), fx(2), fx(3), 0, 0, 0, fx(0), fx(0), fx(0),
                         fx(5), fx(5), fx(5));
      row.has_exp = 1; row.exp = '{1, 1, rbi_pkg::AXIS_X, '{fx(1), fx(2), fx(3)}};
      rows.push_back(row);
      // Origin on the faces counts as inside.
      row.req = make_req(fx(0), fx(5), fx(0), fx(1), 0, 0, fx(0), fx(0), fx(0),
                         fx(5), fx(5), fx(5));
      row.exp = '{1, 1, rbi_pkg::AXIS_X, '{fx(0), fx(5), fx(0)}};
      rows.push_back(row);
      // Whole range box with extreme origin.
      row.req = make_req(mn, mx, mn, mx, mn, mx, mn, mn, mn, mx, mx, mx);
      row.exp = '{1, 1, rbi_pkg::AXIS_X, '{mn, mx, mn}};
      rows.push_back(row);
      // Outside with all directions zero: miss.
      row.req = make_req(fx(-10), fx(1), fx(1), 0, 0, 0, fx(0), fx(0), fx(0),
                         fx(5), fx(5), fx(5));
      row.exp = miss;
      rows.push_back(row);
      // Pointing away: miss.
      row.req = make_req(fx(-10), fx(1), fx(1), fx(-1), 0, 0, fx(0), fx(0), fx(0),
                         fx(5), fx(5), fx(5));
      rows.push_back(row);
      // Inverted box never holds the origin.
      row.req = make_req(fx(1), fx(1), fx(1), 0, 0, 0, fx(2), fx(0), fx(0),
                         fx(0), fx(5), fx(5));
      rows.push_back(row);
      // Straight hits on each axis, from below and above.
      row.has_exp = 0;
      row.req = make_req(fx(-10), fx(1), fx(1), fx(1), 0, 0, fx(0), fx(0), fx(0),
                         fx(5), fx(5), fx(5)); rows.push_back(row);
      row.req = make_req(fx(1), fx(20), fx(1), 0, fx(-2), 0, fx(0), fx(0), fx(0),
                         fx(5), fx(5), fx(5)); rows.push_back(row);
      row.req = make_req(fx(1), fx(1), fx(-9), 0, 0, fx(3), fx(0), fx(0), fx(0),
                         fx(5), fx(5), fx(5)); rows.push_back(row);
      // Diagonal ray, ties between axes, and a grazing miss.
      row.req = make_req(fx(-1), fx(-1), fx(-1), fx(1), fx(1), fx(1), fx(0), fx(0), fx(0),
                         fx(5), fx(5), fx(5)); rows.push_back(row);
      row.req = make_req(fx(-3), fx(-1), fx(2), fx(1), fx(1), 0, fx(0), fx(0), fx(0),
                         fx(5), fx(5), fx(5)); rows.push_back(row);
      row.req = make_req(fx(-1), fx(-1), fx(1), fx(1), fx(7), 0, fx(0), fx(0), fx(0),
                         fx(5), fx(5), fx(5)); rows.push_back(row);
      // Saturating quotient and clamped products.
      row.req = make_req(mn, fx(1), fx(1), 1, mx, mn, fx(0), fx(0), fx(0),
                         mx, fx(5), fx(5)); rows.push_back(row);
      row.req = make_req(mx, mn, mx, mn, 1, -1, mn, fx(0), mn, fx(0), mx, fx(0));
      rows.push_back(row);
      row.req = make_req(mn, mn, mn, mx, mx, mx, mx, mx, mx, mx, mx, mx);
      rows.push_back(row);
      row.req = make_req(-1, -1, -1, 1, 1, 1, 0, 0, 0, 0, 0, 0); rows.push_back(row);
      row.req = make_req(mx, mx, mx, mn, mn, mn, mn, mn, mn, mn, mn, mn);
      rows.push_back(row);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         send_request(rows[i].req);
         if (rows[i].has_exp) pending_hits[pending_hits.size() - 1] = rows[i].exp;
         if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 20));
      end
      // Let the pipeline drain completely once.
      start <= 1'b0;
      while (pending_hits.size() != 0) @(negedge clock);

      for (int n = 0; n < NUM_RANDOM; n += burst) begin
         burst = $urandom_range(1, 40);
         for (int k = 0; k < burst; k++) send_request(rand_req());
         if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 25));
      end
      start <= 1'b0;

      while (pending_hits.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      finished = 1'b1;
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Watchdog.
   initial begin
      #2_000_000;
      if (!finished) begin
         $display("Mismatches found");
         $finish;
      end
   end

endmodule

### sim.f
+incdir+sv
sv/rbi_pkg.sv
sv/rbi_divider.sv
sv/ray_box_intersection_core.sv
bench/ray_box_intersection_core_test.sv
